// ----- design/fpa_pkg.sv -----
// Shared types and constants for the fixed block pool allocator.
// No dependencies; used by the top level and its checker.
package fpa_pkg;

   localparam int OSIZE_W  = 16;   // object_size register width
   localparam int OSIZE_IW = 4;    // bits that select one object_size bit
   localparam int CAP_W    = 11;   // capacity register width

   // Result status codes
   localparam logic [2:0] ST_ALLOC    = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_FREED    = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_NONELIVE = 3'd4;

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Register index, taken from paddr[3:2]
   localparam logic [1:0] REG_POOL_BASE   = 2'd0;
   localparam logic [1:0] REG_OBJECT_SIZE = 2'd1;
   localparam logic [1:0] REG_CAPACITY    = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [31:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] slot_addr;
      logic [9:0]  slot_index;
      logic [10:0] live_count;
   } rsp_type;

endpackage

// ----- design/fpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- design/fixed_block_pool_allocator.sv -----
// Fixed block pool allocator: free-slot stack, live count, shared add/subtract unit.
// Depends on fpa_pkg and fpa_ram.
//
//   channel   ports                                   handshake
//   command   start, busy, req_word                   taken when start && !busy
//   result    rsp_valid, rsp_word                     one-cycle strobe, no backpressure
//   config    psel penable pwrite paddr pwdata        write on access phase, pready tied high
//             prdata pready
//
// One shared adder/subtractor (ADDR_WIDTH+1 bits) does the slot address arithmetic.
// Free: offset subtract in the accept cycle, then ADDR_WIDTH restoring divide steps
// and a finish state. Allocate: stack read (only when popping), 16 shift-add steps
// of the slot offset, one base add. A full pool, or a free below the base or with
// a zero stride, answers without raising busy.
// The result word is on the ports in the first cycle with busy low again (the cycle right
// after the accept when busy never rose). Reset is synchronous and needs no clearing
// pass; the stack memory is only read where it was written.
module fixed_block_pool_allocator #(
   parameter int POOL_DEPTH = 1024,
   parameter int ADDR_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fpa_pkg::req_type req_word,
   output logic             rsp_valid,
   output fpa_pkg::rsp_type rsp_word,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW    = ADDR_WIDTH;
   localparam int UW    = AW + 1;
   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int CW    = (CNT_W > fpa_pkg::CAP_W) ? CNT_W : fpa_pkg::CAP_W;
   localparam int QW    = (AW > CNT_W) ? AW : CNT_W;
   localparam int STW   = $clog2(AW);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POP  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_BASE = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   // configuration registers
   logic [31:0]                   pool_base_ff;
   logic [fpa_pkg::OSIZE_W-1:0]   osize_ff;
   logic [fpa_pkg::CAP_W-1:0]     cap_ff;

   logic [2:0]       state_ff, state_in;
   logic [STW-1:0]   step_ff, step_in;
   logic [AW-1:0]    acc_ff, acc_in;
   logic [AW-1:0]    quo_ff, quo_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fpa_pkg::rsp_type rsp_ff, rsp_in;

   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [IDX_W-1:0] ram_rd_data;
   logic [CNT_W-1:0] top_dec;

   logic [UW-1:0] op_x;
   logic [UW-1:0] op_y;
   logic          op_sub;
   logic [UW:0]   unit_sum;
   logic          unit_carry;
   logic [AW-1:0] unit_diff;

   logic [AW-1:0]    base_a;
   logic [AW-1:0]    addr_a;
   logic [CNT_W-1:0] cap_eff;
   logic             cfg_wr;

   assign base_a = AW'(pool_base_ff);
   assign addr_a = AW'(req_word.free_addr);
   assign cap_eff = (CW'(cap_ff) < CW'(POOL_DEPTH)) ? CNT_W'(cap_ff) : CNT_W'(POOL_DEPTH);
   assign top_dec = top_ff - CNT_W'(1);
   assign ram_rd_addr = top_dec[IDX_W-1:0];

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         osize_ff     <= fpa_pkg::OSIZE_W'(16);
         cap_ff       <= fpa_pkg::CAP_W'(1024);
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            fpa_pkg::REG_POOL_BASE:   pool_base_ff <= pwdata;
            fpa_pkg::REG_OBJECT_SIZE: osize_ff     <= pwdata[fpa_pkg::OSIZE_W-1:0];
            fpa_pkg::REG_CAPACITY:    cap_ff       <= pwdata[fpa_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         fpa_pkg::REG_POOL_BASE:   prdata = pool_base_ff;
         fpa_pkg::REG_OBJECT_SIZE: prdata = 32'(osize_ff);
         fpa_pkg::REG_CAPACITY:    prdata = 32'(cap_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------- shared add/subtract unit ----------------
   always_comb begin
      op_x   = '0;
      op_y   = '0;
      op_sub = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            op_x   = UW'(addr_a);
            op_y   = UW'(base_a);
            op_sub = 1'b1;
         end
         S_MUL: begin
            op_x = UW'({acc_ff[AW-2:0], 1'b0});
            op_y = osize_ff[step_ff[fpa_pkg::OSIZE_IW-1:0]] ? UW'(idx_ff) : '0;
         end
         S_BASE: begin
            op_x = UW'(acc_ff);
            op_y = UW'(base_a);
         end
         S_DIV: begin
            op_x   = {acc_ff, quo_ff[AW-1]};
            op_y   = UW'(osize_ff);
            op_sub = 1'b1;
         end
         default: ;
      endcase
   end

   assign unit_sum   = {1'b0, op_x} + {1'b0, (op_sub ? ~op_y : op_y)} + (UW+1)'(op_sub);
   assign unit_carry = unit_sum[UW];
   assign unit_diff  = unit_sum[AW-1:0];

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      idx_in       = idx_ff;
      top_in       = top_ff;
      live_in      = live_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_word.cmd == fpa_pkg::CMD_ALLOC) begin
                  if (top_ff != '0) begin
                     ram_rd_en = 1'b1;
                     top_in    = top_dec;
                     live_in   = live_ff + CNT_W'(1);
                     state_in  = S_POP;
                  end else if (live_ff < cap_eff) begin
                     idx_in   = live_ff[IDX_W-1:0];
                     live_in  = live_ff + CNT_W'(1);
                     acc_in   = '0;
                     step_in  = STW'(fpa_pkg::OSIZE_W - 1);
                     state_in = S_MUL;
                  end else begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = fpa_pkg::ST_FULL;
                     rsp_in.slot_addr  = '0;
                     rsp_in.slot_index = '0;
                     rsp_in.live_count = 11'(live_ff);
                  end
               end else begin
                  // below base or zero stride: reject without dividing
                  if (!unit_carry || osize_ff == '0) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = fpa_pkg::ST_RANGE;
                     rsp_in.slot_addr  = '0;
                     rsp_in.slot_index = '0;
                     rsp_in.live_count = 11'(live_ff);
                  end else begin
                     quo_in   = unit_diff;
                     acc_in   = '0;
                     step_in  = STW'(AW - 1);
                     state_in = S_DIV;
                  end
               end
            end
         end
         S_POP: begin
            idx_in   = ram_rd_data;
            acc_in   = '0;
            step_in  = STW'(fpa_pkg::OSIZE_W - 1);
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in  = unit_diff;
            step_in = step_ff - STW'(1);
            if (step_ff == '0) begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            rsp_valid_in      = 1'b1;
            rsp_in.status     = fpa_pkg::ST_ALLOC;
            rsp_in.slot_addr  = 32'(unit_diff);
            rsp_in.slot_index = 10'(idx_ff);
            rsp_in.live_count = 11'(live_ff);
            state_in          = S_IDLE;
         end
         S_DIV: begin
            // restoring step: keep the partial remainder when the subtract borrows
            acc_in  = unit_carry ? unit_diff : op_x[AW-1:0];
            quo_in  = {quo_ff[AW-2:0], unit_carry};
            step_in = step_ff - STW'(1);
            if (step_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            rsp_valid_in     = 1'b1;
            rsp_in.slot_addr = '0;
            state_in         = S_IDLE;
            if (QW'(quo_ff) >= QW'(cap_eff)) begin
               rsp_in.status     = fpa_pkg::ST_RANGE;
               rsp_in.slot_index = '0;
               rsp_in.live_count = 11'(live_ff);
            end else if (live_ff == '0) begin
               rsp_in.status     = fpa_pkg::ST_NONELIVE;
               rsp_in.slot_index = '0;
               rsp_in.live_count = 11'(live_ff);
            end else begin
               // drop the push when the stack is already full
               if (top_ff < CNT_W'(POOL_DEPTH)) begin
                  ram_wr_en = 1'b1;
                  top_in    = top_ff + CNT_W'(1);
               end
               live_in           = live_ff - CNT_W'(1);
               rsp_in.status     = fpa_pkg::ST_FREED;
               rsp_in.slot_index = 10'(quo_ff[IDX_W-1:0]);
               rsp_in.live_count = 11'(live_ff - CNT_W'(1));
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   fpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (POOL_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (top_ff[IDX_W-1:0]),
      .wr_data (quo_ff[IDX_W-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- design/fpa_checker.sv -----
// Port-level checks for the fixed block pool allocator, bound to the top level.
// Depends on fpa_pkg.
module fpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input fpa_pkg::req_type req_word,
   input logic             rsp_valid,
   input fpa_pkg::rsp_type rsp_word,
   input logic             psel,
   input logic             penable,
   input logic             pwrite,
   input logic [3:0]       paddr,
   input logic [31:0]      pwdata,
   input logic [31:0]      prdata,
   input logic             pready
);

   // a word only follows a command in flight or one just taken
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result word without a command");

   // finishing a command always produces its word
   a_done_gives_word: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("command finished without a result word");

   a_addr_only_on_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != fpa_pkg::ST_ALLOC |-> rsp_word.slot_addr == '0)
      else $error("slot address on a non-allocate result");

   a_alloc_is_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == fpa_pkg::ST_ALLOC |-> rsp_word.live_count != '0)
      else $error("allocate left no live slot");

endmodule

bind fixed_block_pool_allocator fpa_checker u_fpa_checker (.*);

// ----- tb/sv/fixed_block_pool_allocator_tb.sv -----
// Self-checking testbench for fixed_block_pool_allocator: directed table, then random phases.
// Depends on fpa_pkg and the allocator RTL; checks result words against a table or shadow model.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_tb;
   import fpa_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int STALL_LIMIT  = 2000;
   localparam int PRINT_LIMIT  = 200;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 225;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind;

   typedef struct packed {
      row_kind     kind;
      logic [1:0]  reg_sel;
      logic [31:0] reg_value;
      req_type     word;
      logic        typed;
      rsp_type     want;
   } plan_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_word = '0;
   logic        rsp_valid;
   rsp_type     rsp_word;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // shadow copy of the allocator state and its registers
   logic [9:0]  shadow_stack [0:DEPTH-1];
   logic [10:0] shadow_top = '0;
   logic [10:0] shadow_live = '0;
   logic [31:0] shadow_base = '0;
   logic [15:0] shadow_osize = 16'd16;
   logic [10:0] shadow_cap = 11'd1024;

   rsp_type     due_results [$];
   rsp_type     oldest_due;
   logic [9:0]  held_slots [$];
   plan_row     directed_plan [$];

   int mismatches = 0;
   int checked = 0;
   int sent_allocs = 0;
   int sent_frees = 0;
   int csr_writes = 0;
   int stall_cycles = 0;

   fixed_block_pool_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #4 clock = ~clock;

   function automatic rsp_type predict_pool_op(req_type w);
      rsp_type     r;
      logic [31:0] room;
      logic [31:0] q;
      logic [9:0]  idx;
      logic        ok;
      r = '0;
      idx = '0;
      ok = 1'b1;
      room = (shadow_cap < 11'd1024) ? 32'(shadow_cap) : 32'd1024;
      if (w.cmd == CMD_ALLOC) begin
         if (shadow_top > 0 && shadow_top <= 11'd1024) begin
            shadow_top = shadow_top - 11'd1;
            idx = shadow_stack[shadow_top];
            shadow_live = shadow_live + 11'd1;
         end else if (32'(shadow_live) < room) begin
            idx = shadow_live[9:0];
            shadow_live = shadow_live + 11'd1;
         end else begin
            ok = 1'b0;
         end
         if (ok) begin
            r.status = ST_ALLOC;
            r.slot_index = idx;
            r.slot_addr = shadow_base + 32'(idx) * 32'(shadow_osize);
         end else begin
            r.status = ST_FULL;
         end
      end else begin
         if (w.free_addr < shadow_base || shadow_osize == 16'd0) begin
            r.status = ST_RANGE;
         end else begin
            q = (w.free_addr - shadow_base) / 32'(shadow_osize);
            if (q >= room) begin
               r.status = ST_RANGE;
            end else if (shadow_live == 11'd0) begin
               r.status = ST_NONELIVE;
            end else begin
               // a push onto a full stack is dropped, the free still counts
               if (shadow_top < 11'd1024) begin
                  shadow_stack[shadow_top] = q[9:0];
                  shadow_top = shadow_top + 11'd1;
               end
               shadow_live = shadow_live - 11'd1;
               r.status = ST_FREED;
               r.slot_index = q[9:0];
            end
         end
      end
      r.live_count = shadow_live;
      return r;
   endfunction

   function automatic plan_row item_row(logic cmd, logic [31:0] addr);
      plan_row r;
      r = '0;
      r.kind = ROW_ITEM;
      r.word.cmd = cmd;
      r.word.free_addr = addr;
      return r;
   endfunction

   function automatic plan_row typed_row(logic cmd, logic [31:0] addr, logic [2:0] st,
                                         logic [31:0] saddr, logic [9:0] sidx,
                                         logic [10:0] live);
      plan_row r;
      r = item_row(cmd, addr);
      r.typed = 1'b1;
      r.want.status = st;
      r.want.slot_addr = saddr;
      r.want.slot_index = sidx;
      r.want.live_count = live;
      return r;
   endfunction

   function automatic plan_row cfg_row(logic [1:0] sel, logic [31:0] value);
      plan_row r;
      r = '0;
      r.kind = ROW_CFG;
      r.reg_sel = sel;
      r.reg_value = value;
      return r;
   endfunction

   // Present one command word after a gap, hold it until taken, log its expected result.
   task automatic issue_word(input req_type w, input logic typed, input rsp_type want,
                             input int gap);
      rsp_type guess;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      guess = predict_pool_op(w);
      due_results.push_back(typed ? want : guess);
      if (guess.status == ST_ALLOC) held_slots.push_back(guess.slot_index);
      if (w.cmd == CMD_ALLOC) sent_allocs++;
      else sent_frees++;
   endtask

   // Drop start and hold until every outstanding result has come back.
   task automatic drain;
      start <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write one register, then read it back, and let the bus go idle before returning.
   task automatic csr_access(input logic [1:0] sel, input logic [31:0] value);
      logic [31:0] mask;
      mask = (sel == REG_POOL_BASE) ? 32'hFFFF_FFFF :
             (sel == REG_OBJECT_SIZE) ? 32'h0000_FFFF : 32'h0000_07FF;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if ((prdata & mask) !== (value & mask)) begin
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t: register %0d read back expected %h actual %h",
                     $time, sel, value & mask, prdata & mask);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      case (sel)
         REG_POOL_BASE:   shadow_base = value;
         REG_OBJECT_SIZE: shadow_osize = value[15:0];
         REG_CAPACITY:    shadow_cap = value[10:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   // result checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
               $display("%0t: unexpected result word expected none actual %p",
                        $time, rsp_word);
         end else begin
            oldest_due = due_results.pop_front();
            checked++;
            if (rsp_word.status !== oldest_due.status ||
                rsp_word.slot_addr !== oldest_due.slot_addr ||
                rsp_word.slot_index !== oldest_due.slot_index ||
                rsp_word.live_count !== oldest_due.live_count) begin
               mismatches++;
               if (mismatches <= PRINT_LIMIT)
                  $display("%0t: result expected %p actual %p", $time, oldest_due, rsp_word);
            end
         end
      end
   end

   // watchdog: count cycles in which no word moves on any port
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("Timeout after %0d quiet cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   int          ph;
   int          n;
   int          k;
   int          alloc_pct;
   int          pick;
   logic        burst;
   logic [31:0] new_base;
   logic [15:0] new_osize;
   logic [10:0] new_cap;
   logic [31:0] room;
   logic [31:0] addr;
   logic [9:0]  slot;
   req_type     w;

   initial begin
      // reset register values first
      directed_plan.push_back(typed_row(CMD_FREE, 32'h0, ST_NONELIVE, 32'h0, 10'd0, 11'd0));
      directed_plan.push_back(typed_row(CMD_FREE, 32'h4000, ST_RANGE, 32'h0, 10'd0, 11'd0));
      directed_plan.push_back(typed_row(CMD_ALLOC, 32'h0, ST_ALLOC, 32'h0, 10'd0, 11'd1));
      directed_plan.push_back(typed_row(CMD_ALLOC, 32'hFFFF_FFFF, ST_ALLOC, 32'h10, 10'd1,
                                        11'd2));
      directed_plan.push_back(typed_row(CMD_FREE, 32'h1F, ST_FREED, 32'h0, 10'd1, 11'd1));
      directed_plan.push_back(typed_row(CMD_ALLOC, 32'h0, ST_ALLOC, 32'h10, 10'd1, 11'd2));
      directed_plan.push_back(typed_row(CMD_FREE, 32'hFFFF_FFFF, ST_RANGE, 32'h0, 10'd0,
                                        11'd2));
      // top slot freed twice in a row, then handed out twice
      directed_plan.push_back(typed_row(CMD_FREE, 32'h3FF0, ST_FREED, 32'h0, 10'd1023, 11'd1));
      directed_plan.push_back(typed_row(CMD_FREE, 32'h3FFF, ST_FREED, 32'h0, 10'd1023, 11'd0));
      directed_plan.push_back(typed_row(CMD_FREE, 32'h0, ST_NONELIVE, 32'h0, 10'd0, 11'd0));
      directed_plan.push_back(typed_row(CMD_ALLOC, 32'h0, ST_ALLOC, 32'h3FF0, 10'd1023,
                                        11'd1));
      directed_plan.push_back(typed_row(CMD_ALLOC, 32'h0, ST_ALLOC, 32'h3FF0, 10'd1023,
                                        11'd2));
      directed_plan.push_back(typed_row(CMD_ALLOC, 32'h0, ST_ALLOC, 32'h20, 10'd2, 11'd3));
      directed_plan.push_back(typed_row(CMD_FREE, 32'h3FF0, ST_FREED, 32'h0, 10'd1023, 11'd2));
      // capacity lowered to the live count, base near the top, widest stride
      directed_plan.push_back(cfg_row(REG_POOL_BASE, 32'hFFFF_FFF0));
      directed_plan.push_back(cfg_row(REG_OBJECT_SIZE, 32'h0000_FFFF));
      directed_plan.push_back(cfg_row(REG_CAPACITY, 32'd2));
      directed_plan.push_back(item_row(CMD_ALLOC, 32'h0));
      directed_plan.push_back(typed_row(CMD_ALLOC, 32'h0, ST_FULL, 32'h0, 10'd0, 11'd3));
      directed_plan.push_back(typed_row(CMD_FREE, 32'h0, ST_RANGE, 32'h0, 10'd0, 11'd3));
      directed_plan.push_back(item_row(CMD_FREE, 32'hFFFF_FFFF));
      // zero stride
      directed_plan.push_back(cfg_row(REG_OBJECT_SIZE, 32'h0));
      directed_plan.push_back(typed_row(CMD_FREE, 32'hFFFF_FFF5, ST_RANGE, 32'h0, 10'd0,
                                        11'd2));
      directed_plan.push_back(item_row(CMD_ALLOC, 32'h0));
      // zero capacity
      directed_plan.push_back(cfg_row(REG_POOL_BASE, 32'h0));
      directed_plan.push_back(cfg_row(REG_OBJECT_SIZE, 32'h1));
      directed_plan.push_back(cfg_row(REG_CAPACITY, 32'd0));
      directed_plan.push_back(typed_row(CMD_FREE, 32'h0, ST_RANGE, 32'h0, 10'd0, 11'd3));
      directed_plan.push_back(typed_row(CMD_ALLOC, 32'h0, ST_FULL, 32'h0, 10'd0, 11'd3));
      // capacity above the pool depth
      directed_plan.push_back(cfg_row(REG_CAPACITY, 32'd2047));
      directed_plan.push_back(item_row(CMD_FREE, 32'h3FF));
      directed_plan.push_back(item_row(CMD_FREE, 32'h400));
      directed_plan.push_back(item_row(CMD_ALLOC, 32'h0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CFG) begin
            drain();
            csr_access(directed_plan[i].reg_sel, directed_plan[i].reg_value);
         end else begin
            issue_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want,
                       $urandom_range(12));
         end
      end

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin
               new_base = 32'h0; new_osize = 16'd16; new_cap = 11'd1024; alloc_pct = 80;
            end
            1: begin
               new_base = $urandom(); new_osize = 16'($urandom_range(1, 64));
               new_cap = 11'd8; alloc_pct = 55;
            end
            2: begin
               new_base = 32'hFFFF_FF00 | 32'($urandom_range(255)); new_osize = 16'hFFFF;
               new_cap = 11'd1024; alloc_pct = 60;
            end
            3: begin
               new_base = $urandom(); new_osize = 16'd1; new_cap = 11'd1; alloc_pct = 50;
            end
            4: begin
               new_base = $urandom(); new_osize = 16'd0; new_cap = 11'd3; alloc_pct = 50;
            end
            5: begin
               new_base = $urandom(); new_osize = 16'($urandom_range(1, 65535));
               new_cap = 11'd2047; alloc_pct = 60;
            end
            6: begin
               new_base = 32'hFFFF_FFFF; new_osize = 16'($urandom_range(1, 65535));
               new_cap = 11'd0; alloc_pct = 50;
            end
            default: begin
               new_base = $urandom(); new_osize = 16'($urandom_range(1, 300));
               new_cap = 11'($urandom_range(1, 1024)); alloc_pct = 45;
            end
         endcase
         drain();
         csr_access(REG_POOL_BASE, new_base);
         csr_access(REG_OBJECT_SIZE, 32'(new_osize));
         csr_access(REG_CAPACITY, 32'(new_cap));
         burst = ($urandom_range(2) == 0);
         room = (shadow_cap < 11'd1024) ? 32'(shadow_cap) : 32'd1024;

         for (n = 0; n < PHASE_ITEMS; n++) begin
            w.free_addr = $urandom();
            if ($urandom_range(99) < alloc_pct) begin
               w.cmd = CMD_ALLOC;
            end else begin
               w.cmd = CMD_FREE;
               pick = $urandom_range(99);
               if (pick < 65 && held_slots.size() != 0) begin
                  // return a slot that is out, at some byte inside it
                  k = $urandom_range(held_slots.size() - 1);
                  slot = held_slots[k];
                  held_slots.delete(k);
                  addr = shadow_base + 32'(slot) * 32'(shadow_osize);
                  if (shadow_osize > 16'd1) addr = addr + $urandom_range(32'(shadow_osize) - 1);
                  w.free_addr = addr;
               end else if (pick < 75) begin
                  w.free_addr = $urandom();
               end else if (pick < 82) begin
                  w.free_addr = shadow_base - 32'd1 - 32'($urandom_range(3));
               end else if (pick < 90) begin
                  w.free_addr = shadow_base + room * 32'(shadow_osize)
                                - 32'($urandom_range(1)) * 32'(shadow_osize);
               end else if (pick < 95) begin
                  w.free_addr = shadow_base + 32'($urandom_range(2047)) * 32'(shadow_osize);
               end else begin
                  w.free_addr = pick[0] ? 32'hFFFF_FFFF : 32'h0;
               end
            end
            issue_word(w, 1'b0, '0, burst ? 0 : $urandom_range(12));
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Ran %0d allocate and %0d free commands over %0d register writes",
               sent_allocs, sent_frees, csr_writes);
      $display("Checked %0d result words, %0d still outstanding", checked, due_results.size());
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
